### rtl/mlfs_pkg.sv
// Package for the multilevel feedback scheduler.
// Types, constants and codes shared by the interfaces, controller and datapath.
package mlfs_pkg;
   localparam int MaxProcs = 16;
   localparam int PtrW = $clog2(MaxProcs);
   localparam int CntW = $clog2(MaxProcs + 1);

   localparam logic [4:0] IdleCode = 5'h1F;
   localparam logic [15:0] ResetQuantum0 = 16'd10;
   localparam logic [15:0] ResetQuantum1 = 16'd15;
   localparam logic [15:0] ResetIoTime = 16'd20;

   localparam logic [1:0] CsrQuantum0 = 2'd0;
   localparam logic [1:0] CsrQuantum1 = 2'd1;
   localparam logic [1:0] CsrIoTime = 2'd2;

   localparam logic [1:0] QLevel0 = 2'd0;
   localparam logic [1:0] QLevel1 = 2'd1;
   localparam logic [1:0] QLevel2 = 2'd2;
   localparam logic [1:0] QIo = 2'd3;

   typedef struct packed {
      logic [3:0] id;
      logic [15:0] burst;
      logic [15:0] remain;
      logic [7:0] ops;
      logic [15:0] cnt;
   } rec_type;

   typedef struct packed {
      logic mode;
      logic [3:0] proc_id;
      logic [15:0] burst;
      logic [7:0] io_ops;
   } req_type;

   typedef struct packed {
      logic [31:0] time_now;
      logic [4:0] run_id;
      logic segment_start;
      logic all_done;
      logic admit_rejected;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_IO_READ, ST_IO_EXEC, ST_CPU_READ, ST_CPU_EXEC, ST_RESPOND
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic do_admit;
      logic io_read;
      logic io_exec;
      logic cpu_read;
      logic cpu_exec;
      logic send;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_tick;
      logic all_empty;
      logic io_nonempty;
      logic rsp_busy;
   } status_type;
endpackage

### rtl/mlfs_stream_if.sv
// Valid/ready channel interface carrying one payload word.
// Depends on mlfs_pkg for nothing; the payload width is an interface parameter.
interface mlfs_stream_if #(parameter int Width = 1) (input logic clock);
   logic valid;
   logic ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/mlfs_ctrl.sv
// Controller of the scheduler: sequences admit and tick through the datapath.
// Depends on mlfs_pkg.
module mlfs_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input mlfs_pkg::status_type status,
   output mlfs_pkg::cmd_type cmd
);
   import mlfs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_IO_READ;
         end
         ST_IO_READ: begin
            if (!status.is_tick || status.all_empty) state_in = ST_RESPOND;
            else if (status.io_nonempty) state_in = ST_IO_EXEC;
            else state_in = ST_CPU_READ;
         end
         ST_IO_EXEC: state_in = ST_CPU_READ;
         ST_CPU_READ: state_in = ST_CPU_EXEC;
         ST_CPU_EXEC: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_IO_READ: begin
            cmd.io_read = 1'b1;
            cmd.do_admit = !status.is_tick;
         end
         ST_IO_EXEC: cmd.io_exec = 1'b1;
         ST_CPU_READ: cmd.cpu_read = 1'b1;
         ST_CPU_EXEC: cmd.cpu_exec = 1'b1;
         ST_RESPOND: cmd.send = !status.rsp_busy;
         default: cmd = '0;
      endcase
   end
endmodule

### rtl/mlfs_datapath.sv
// Datapath of the scheduler: four record FIFOs, configuration, time and output register.
// Depends on mlfs_pkg.
module mlfs_datapath (
   input logic clock,
   input logic reset,
   input mlfs_pkg::req_type req_data,
   input logic csr_write,
   input logic [1:0] csr_index,
   input logic [15:0] csr_value,
   input mlfs_pkg::cmd_type cmd,
   output mlfs_pkg::status_type status,
   output logic rsp_valid,
   input logic rsp_ready,
   output mlfs_pkg::rsp_type rsp_data
);
   import mlfs_pkg::*;

   rec_type mem_ff [4][MaxProcs];
   logic [PtrW-1:0] head_ff [4];
   logic [CntW-1:0] count_ff [4];
   logic [15:0] quantum0_ff, quantum1_ff, io_time_ff;
   logic [31:0] tick_ff;
   logic [4:0] last_ff;
   req_type req_ff;
   rec_type io_front_ff, cpu_front_ff;
   logic [1:0] cpu_lvl_ff;
   logic cpu_any_ff;
   logic [4:0] ran_ff;
   logic seg_ff, rej_ff, done_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic [3:0] full, empty;
   always_comb begin
      for (int q = 0; q < 4; q++) begin
         full[q] = (count_ff[q] == CntW'(MaxProcs));
         empty[q] = (count_ff[q] == '0);
      end
   end

   // Queue operations requested this cycle: at most one write into each FIFO.
   logic [3:0] push, pop, upd;
   rec_type push_rec [4];
   rec_type upd_rec [4];

   rec_type io_ret, io_next, cpu_rec;
   logic io_done, cpu_leave;
   logic [15:0] quantum;
   always_comb begin
      io_ret = io_front_ff;
      io_ret.cnt = '0;
      io_ret.remain = io_front_ff.burst;
      io_ret.ops = io_front_ff.ops - 8'd1;
      io_done = (io_front_ff.cnt >= io_time_ff);
      io_next = io_front_ff;
      io_next.cnt = io_front_ff.cnt + 16'd1;
      cpu_rec = cpu_front_ff;
      cpu_rec.remain = cpu_front_ff.remain - 16'd1;
      cpu_rec.cnt = cpu_front_ff.cnt + 16'd1;
      quantum = (cpu_lvl_ff == QLevel0) ? quantum0_ff : quantum1_ff;
      cpu_leave = (cpu_rec.remain == '0) ||
                  (cpu_lvl_ff != QLevel2 && cpu_rec.cnt == quantum);
      if (cpu_leave) cpu_rec.cnt = '0;
   end

   // The I/O entry after the current front, read when the front returns.
   rec_type io_second;
   assign io_second = mem_ff[QIo][head_ff[QIo] + PtrW'(1)];

   always_comb begin
      push = '0;
      pop = '0;
      upd = '0;
      for (int q = 0; q < 4; q++) begin
         push_rec[q] = cpu_rec;
         upd_rec[q] = cpu_rec;
      end
      if (cmd.do_admit && !full[QLevel0]) begin
         push[QLevel0] = 1'b1;
         push_rec[QLevel0] = '{id: req_ff.proc_id, burst: req_ff.burst,
                                remain: req_ff.burst, ops: req_ff.io_ops, cnt: 16'd0};
      end
      if (cmd.io_exec) begin
         if (io_done) begin
            pop[QIo] = 1'b1;
            push[QLevel0] = !full[QLevel0];
            push_rec[QLevel0] = io_ret;
            if (count_ff[QIo] > CntW'(1)) begin
               upd[QIo] = 1'b1;
               upd_rec[QIo] = io_second;
               upd_rec[QIo].cnt = io_second.cnt + 16'd1;
            end
         end else begin
            upd[QIo] = 1'b1;
            upd_rec[QIo] = io_next;
         end
      end
      if (cmd.cpu_exec && cpu_any_ff) begin
         if (cpu_leave) begin
            pop[cpu_lvl_ff] = 1'b1;
            if (cpu_rec.remain != '0) begin
               if (cpu_lvl_ff != QLevel2) begin
                  push[cpu_lvl_ff + 2'd1] = !full[cpu_lvl_ff + 2'd1];
               end
            end else if (cpu_rec.ops != '0) begin
               push[QIo] = !full[QIo];
            end
         end else begin
            upd[cpu_lvl_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int q = 0; q < 4; q++) begin
         if (push[q]) mem_ff[q][head_ff[q] + PtrW'(count_ff[q])] <= push_rec[q];
         if (upd[q]) mem_ff[q][pop[q] ? head_ff[q] + PtrW'(1) : head_ff[q]] <= upd_rec[q];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < 4; q++) begin
            head_ff[q] <= '0;
            count_ff[q] <= '0;
         end
      end else begin
         for (int q = 0; q < 4; q++) begin
            if (pop[q]) head_ff[q] <= head_ff[q] + PtrW'(1);
            count_ff[q] <= count_ff[q] + CntW'(push[q]) - CntW'(pop[q]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum0_ff <= ResetQuantum0;
         quantum1_ff <= ResetQuantum1;
         io_time_ff <= ResetIoTime;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrQuantum0: quantum0_ff <= csr_value;
            CsrQuantum1: quantum1_ff <= csr_value;
            CsrIoTime: io_time_ff <= csr_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.io_read) io_front_ff <= mem_ff[QIo][head_ff[QIo]];
      if (cmd.io_read) begin
         rej_ff <= !req_ff.mode && full[QLevel0];
         done_ff <= req_ff.mode && (&empty);
      end
      if (cmd.cpu_read) begin
         cpu_any_ff <= !(empty[QLevel0] && empty[QLevel1] && empty[QLevel2]);
         priority if (!empty[QLevel0]) begin
            cpu_lvl_ff <= QLevel0;
            cpu_front_ff <= mem_ff[QLevel0][head_ff[QLevel0]];
         end else if (!empty[QLevel1]) begin
            cpu_lvl_ff <= QLevel1;
            cpu_front_ff <= mem_ff[QLevel1][head_ff[QLevel1]];
         end else begin
            cpu_lvl_ff <= QLevel2;
            cpu_front_ff <= mem_ff[QLevel2][head_ff[QLevel2]];
         end
      end
   end

   logic [4:0] ran_code;
   assign ran_code = cpu_any_ff ? {1'b0, cpu_front_ff.id} : IdleCode;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         last_ff <= IdleCode;
      end else if (cmd.cpu_exec) begin
         tick_ff <= tick_ff + 32'd1;
         last_ff <= ran_code;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.io_read) begin
         ran_ff <= IdleCode;
         seg_ff <= 1'b0;
      end else if (cmd.cpu_exec) begin
         ran_ff <= ran_code;
         seg_ff <= (ran_code != last_ff);
      end
   end

   // Output register: time is the value before this tick's increment.
   logic [31:0] time_shown;
   assign time_shown = (req_ff.mode && !done_ff) ? tick_ff - 32'd1 : tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         rsp_ff <= '{time_now: time_shown, run_id: ran_ff, segment_start: seg_ff,
                     all_done: done_ff, admit_rejected: rej_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign status.is_tick = req_ff.mode;
   assign status.all_empty = &empty;
   assign status.io_nonempty = !empty[QIo];
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
endmodule

### rtl/multilevel_feedback_scheduler_unit.sv
// Channel   Dir  Payload
// req       in   mode, proc_id, burst, io_ops
// rsp       out  time_now, run_id, segment_start, all_done, admit_rejected
// csr       in   index (2 bits), data (16 bits)
// An admit or finished tick goes from the I/O read step straight to respond; a working tick
// runs an I/O stage then a CPU stage, each a queue-front read then an update (no I/O update
// when the I/O queue is empty). Reset is synchronous and empties all queues at once. A result
// waits in the output register; a stalled result holds the next item at the respond step only.
// Depends on mlfs_pkg, mlfs_stream_if, mlfs_ctrl and mlfs_datapath.
module multilevel_feedback_scheduler_unit (
   input logic clock,
   input logic reset,
   mlfs_stream_if.sink req,
   mlfs_stream_if.source rsp,
   mlfs_stream_if.sink csr
);
   import mlfs_pkg::*;

   cmd_type cmd;
   status_type status;
   rsp_type rsp_word;

   assign csr.ready = 1'b1;
   assign rsp.data = rsp_word;

   mlfs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .status(status), .cmd(cmd)
   );

   mlfs_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_type'(req.data)),
      .csr_write(csr.valid), .csr_index(csr.data[17:16]),
      .csr_value(csr.data[15:0]), .cmd(cmd), .status(status),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp_word)
   );
endmodule

### rtl/mlfs_checker.sv
// Port-level checks for the scheduler, bound to the top level.
// Depends on mlfs_pkg and mlfs_stream_if.
module mlfs_port_checks (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [39:0] rsp_data
);
   import mlfs_pkg::*;
   rsp_type r;
   assign r = rsp_type'(rsp_data);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken before result");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(r.all_done && r.admit_rejected))
      else $error("done and rejected together");
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (r.all_done || r.admit_rejected) |-> r.run_id == IdleCode && !r.segment_start)
      else $error("flagged result with a running id");
endmodule

bind multilevel_feedback_scheduler_unit mlfs_port_checks u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

### tb/mlfs_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the multilevel feedback scheduler: watches the req, csr and rsp channels.
// Keeps its own copy of the scheduler queues and compares every response. Uses mlfs_pkg.
module mlfs_checker (
   input logic clock,
   input logic reset,
   mlfs_stream_if req,
   mlfs_stream_if rsp,
   mlfs_stream_if csr,
   output int fail_count,
   output int pending,
   output int rsp_seen,
   output int rejects_seen
);
   import mlfs_pkg::*;

   rsp_type sched_expected[$];

   rec_type slots[4][MaxProcs];
   int q_head[4];
   int q_count[4];
   logic [31:0] tick_now;
   logic [4:0] last_id;
   logic [15:0] quantum[2];
   logic [15:0] io_ticks;

   function automatic void q_push(int q, rec_type r);
      if (q_count[q] < MaxProcs) begin
         slots[q][(q_head[q] + q_count[q]) % MaxProcs] = r;
         q_count[q]++;
      end
   endfunction

   function automatic void q_pop(int q);
      if (q_count[q] > 0) begin
         q_head[q] = (q_head[q] + 1) % MaxProcs;
         q_count[q]--;
      end
   endfunction

   // Works out the response of one request and advances the scheduler copy.
   function automatic rsp_type sched_step(req_type d);
      rsp_type e;
      rec_type r;
      rec_type f;
      int lvl;
      logic served;
      e = '0;
      e.time_now = tick_now;
      e.run_id = IdleCode;
      if (!d.mode) begin
         r.id = d.proc_id;
         r.burst = d.burst;
         r.remain = d.burst;
         r.ops = d.io_ops;
         r.cnt = '0;
         if (q_count[QLevel0] >= MaxProcs) e.admit_rejected = 1'b1;
         else q_push(QLevel0, r);
      end else if (q_count[0] == 0 && q_count[1] == 0 && q_count[2] == 0 && q_count[3] == 0) begin
         e.all_done = 1'b1;
      end else begin
         if (q_count[QIo] > 0) begin
            served = 1'b1;
            f = slots[QIo][q_head[QIo]];
            if (f.cnt >= io_ticks) begin
               r = f;
               r.cnt = '0;
               r.remain = r.burst;
               r.ops = r.ops - 8'd1;
               q_pop(QIo);
               q_push(QLevel0, r);
               if (q_count[QIo] == 0) served = 1'b0;
            end
            if (served) slots[QIo][q_head[QIo]].cnt = slots[QIo][q_head[QIo]].cnt + 16'd1;
         end
         lvl = -1;
         for (int i = 2; i >= 0; i--) if (q_count[i] > 0) lvl = i;
         if (lvl >= 0) begin
            f = slots[lvl][q_head[lvl]];
            e.run_id = {1'b0, f.id};
            f.remain = f.remain - 16'd1;
            f.cnt = f.cnt + 16'd1;
            if ((lvl < 2 && f.cnt == quantum[lvl]) || f.remain == 16'd0) begin
               f.cnt = '0;
               q_pop(lvl);
               if (f.remain != 16'd0) begin
                  if (lvl < 2) q_push(lvl + 1, f);
               end else if (f.ops != 8'd0) begin
                  q_push(QIo, f);
               end
            end else begin
               slots[lvl][q_head[lvl]] = f;
            end
         end
         e.segment_start = (e.run_id != last_id);
         last_id = e.run_id;
         tick_now = tick_now + 32'd1;
      end
      return e;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            q_head[i] = 0;
            q_count[i] = 0;
         end
         tick_now = '0;
         last_id = IdleCode;
         quantum[0] = ResetQuantum0;
         quantum[1] = ResetQuantum1;
         io_ticks = ResetIoTime;
         sched_expected.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.data[17:16])
               CsrQuantum0: quantum[0] = csr.data[15:0];
               CsrQuantum1: quantum[1] = csr.data[15:0];
               CsrIoTime: io_ticks = csr.data[15:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            rsp_seen++;
            if (got.admit_rejected) rejects_seen++;
            if (sched_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response %p", got);
            end else begin
               want = sched_expected.pop_front();
               if (got.time_now !== want.time_now || got.run_id !== want.run_id ||
                   got.segment_start !== want.segment_start ||
                   got.all_done !== want.all_done ||
                   got.admit_rejected !== want.admit_rejected) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("response mismatch: expected %p, got %p", want, got);
               end
            end
         end
         // The prediction is queued after the compare, so a same-edge transfer never matches.
         if (req.valid && req.ready)
            sched_expected.insert(sched_expected.size(), sched_step(req.data));
      end
      pending = sched_expected.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      rsp_seen = 0;
      rejects_seen = 0;
   end
endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, request and register stimulus, verdict.
// Depends on mlfs_pkg, mlfs_stream_if, mlfs_checker and multilevel_feedback_scheduler_unit.
module tb;
   import mlfs_pkg::*;

   localparam int CycleLimit = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int cycles = 0;
   int fail_count, pending, rsp_seen, rejects_seen;
   int items_sent = 0;
   logic quiet = 1'b0;
   int stall_left = 0;

   mlfs_stream_if #(.Width($bits(req_type))) req (clock);
   mlfs_stream_if #(.Width($bits(rsp_type))) rsp (clock);
   mlfs_stream_if #(.Width(18)) csr (clock);

   multilevel_feedback_scheduler_unit i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   mlfs_checker i_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen),
      .rejects_seen(rejects_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response side back-pressure.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp.ready <= (stall_left == 0);
      end
   end

   // Entered just after a posedge; returns just after the posedge of the transfer.
   task automatic send_req(logic mode, logic [3:0] id, logic [15:0] burst, logic [7:0] ops);
      int g;
      req_type d;
      g = pick_gap();
      d.mode = mode;
      d.proc_id = id;
      d.burst = burst;
      d.io_ops = ops;
      @(negedge clock);
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data <= d;
      forever begin
         #1;
         if (req.ready) begin
            @(posedge clock);
            break;
         end
         @(negedge clock);
      end
      items_sent++;
   endtask

   task automatic tick();
      send_req(1'b1, 4'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(negedge clock);
      req.valid <= 1'b0;
      csr.valid <= 1'b1;
      csr.data <= {idx, value};
      forever begin
         #1;
         if (csr.ready) begin
            @(posedge clock);
            break;
         end
         @(negedge clock);
      end
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // Waits until every predicted response has arrived, then lets the block settle.
   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic configure(logic [15:0] q0, logic [15:0] q1, logic [15:0] io);
      drain();
      write_reg(CsrQuantum0, q0);
      write_reg(CsrQuantum1, q1);
      write_reg(CsrIoTime, io);
   endtask

   task automatic random_phase(int n, logic big);
      logic [15:0] b;
      logic [7:0] ops;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 20) begin
            if (big && $urandom_range(0, 3) == 0) b = 16'($urandom);
            else b = 16'($urandom_range(1, 12));
            if (b == 16'd0) b = 16'd1;
            ops = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            send_req(1'b0, 4'($urandom), b, ops);
         end else begin
            tick();
         end
         if (k % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      end
      quiet = 1'b0;
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      rsp.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queues, minimum quanta, long I/O chain, top queue overflow.
      configure(16'd1, 16'd1, 16'd1);
      tick();
      send_req(1'b0, 4'd1, 16'd1, 8'd1);
      tick();
      tick();
      tick();
      tick();
      send_req(1'b0, 4'd15, 16'd3, 8'd255);
      for (int k = 0; k < 17; k++) send_req(1'b0, 4'(k), 16'd1, 8'd0);
      tick();

      configure(16'd3, 16'd5, 16'd4);
      random_phase(480, 1'b0);
      configure(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 8)));
      random_phase(480, 1'b0);
      configure(16'd2, 16'd65535, 16'd1);
      random_phase(480, 1'b0);
      // Largest settings last, since long bursts can occupy the lowest level for good.
      configure(16'd65535, 16'd65535, 16'd65535);
      random_phase(480, 1'b1);

      drain();
      $display("Sent %0d requests, checked %0d responses, %0d admits rejected",
               items_sent, rsp_seen, rejects_seen);
      $display("Covered five register settings, including both extremes, under random stalls");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
